// ===== hdl/nc4p_pkg.sv =====
// Package for the NC4HW4 fp16 pack block: widths, register indexes and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nc4p_pkg;
    localparam int LANES = 4;
    localparam int MAX_EXTENT = 4096;
    localparam int EXT_W = 13;
    localparam int IDX_W = 44;
    localparam int CFG_IDX_W = 2;
    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;
    localparam logic [1:0] REG_HALF = 2'd3;

    typedef struct packed {
        logic [EXT_W-1:0] channel_count;
        logic [EXT_W-1:0] tensor_height;
        logic [EXT_W-1:0] tensor_width;
        logic             half_mode;
    } t_cfg;
endpackage
`default_nettype wire

// ===== hdl/nc4p_lane.sv =====
// One lane: channel masking and, in half mode, saturating fp32 to fp16 conversion, registered.
// Depends on nc4p_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nc4p_lane (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic        i_keep,
    input  wire logic        i_half,
    input  wire logic [31:0] i_data,
    output logic      [31:0] o_data
);
    import nc4p_pkg::*;

    logic [31:0] v;
    logic [15:0] sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [15:0] h;
    logic [12:0] rem;
    logic [4:0]  s;
    logic [23:0] full, sh, rm, hf;
    logic [15:0] hc;
    logic [31:0] n_data;
    logic [31:0] r_data;

    always_comb begin
        v = i_keep ? i_data : 32'd0;
        sgn = {v[31], 15'd0};
        e = v[30:23];
        m = v[22:0];
        rem = m[12:0];
        h = 16'd0;
        full = {1'b1, m};
        s = 5'd0;
        sh = 24'd0;
        rm = 24'd0;
        hf = 24'd0;
        hc = 16'd0;
        if (e == 8'd255) begin
            hc = (m != 23'd0) ? (sgn | 16'h7E00 | {6'd0, m[22:13]}) : (sgn | 16'h7BFF);
        end else if (e >= 8'd143) begin
            hc = sgn | 16'h7BFF;
        end else if (e >= 8'd113) begin
            h = {1'b0, 5'(e - 8'd112), m[22:13]};
            if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) begin
                h = h + 16'd1;
            end
            if (h >= 16'h7C00) begin
                h = 16'h7BFF;
            end
            hc = sgn | h;
        end else if (e == 8'd0 || (8'd126 - e) > 8'd24) begin
            hc = sgn;
        end else begin
            s = 5'(8'd126 - e);
            sh = full >> s;
            rm = full & ((24'd1 << s) - 24'd1);
            hf = 24'd1 << (s - 5'd1);
            h = sh[15:0];
            if (rm > hf || (rm == hf && h[0])) begin
                h = h + 16'd1;
            end
            hc = sgn | h;
        end
        n_data = i_half ? {16'd0, hc} : v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end
    assign o_data = r_data;
endmodule
`default_nettype wire

// ===== hdl/nc4p_index.sv =====
// Destination index pipeline: one multiply per stage, three stages.
// Depends on nc4p_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nc4p_index (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire nc4p_pkg::t_cfg                i_cfg,
    input  wire logic [7:0]                    i_batch,
    input  wire logic [9:0]                    i_block,
    input  wire logic [11:0]                   i_row,
    input  wire logic [11:0]                   i_col,
    output logic      [nc4p_pkg::IDX_W-1:0]    o_index
);
    import nc4p_pkg::*;

    logic [10:0] blocks;
    logic [19:0] r_a;
    logic [11:0] r_row1, r_col1, r_col2;
    logic [32:0] r_b;
    logic [IDX_W-1:0] r_c;

    assign blocks = 11'((i_cfg.channel_count + 13'd3) >> 2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= 20'(i_batch) * 20'(blocks) + 20'(i_block);
            r_row1 <= i_row;
            r_col1 <= i_col;
            r_b <= 33'(r_a) * 33'(i_cfg.tensor_height) + 33'(r_row1);
            r_col2 <= r_col1;
            r_c <= IDX_W'((46'(r_b) * 46'(i_cfg.tensor_width) + 46'(r_col2)) << 2);
        end
    end
    assign o_index = r_c;
endmodule
`default_nettype wire

// ===== hdl/nc4_block_pack_fp16_top.sv =====
// Top level of the NC4HW4 fp16 pack block: config registers, lanes, index pipe.
// Depends on nc4p_pkg, nc4p_lane and nc4p_index.
`timescale 1ns / 1ps
`default_nettype none
// One word is accepted per cycle unless the pipeline is stalled; results pass
// through the three multiply stages of the index pipeline. The pipeline stalls
// as a whole when a valid output is not taken, and no stage moves while it is held.
module nc4_block_pack_fp16_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // batch_index, channel_block, row_index, column_index, lane0_in..lane3_in
    input  wire logic [175:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // dest_index, lane0_out..lane3_out
    output logic [175:0]       m_axis_tdata
);
    import nc4p_pkg::*;

    t_cfg r_cfg;
    logic [2:0] r_vld;
    logic en;
    logic [EXT_W-1:0] sat;
    logic [LANES-1:0] keep;
    logic [LANES*32-1:0] lout;
    logic [IDX_W-1:0] idx;
    logic [12:0] ch;

    assign en = !r_vld[2] || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready = 1'b1;
    assign sat = (i_cfg_data[12:0] > 13'(MAX_EXTENT)) ? 13'(MAX_EXTENT) : i_cfg_data[12:0];
    assign ch = 13'({s_axis_tdata[17:8], 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{13'd4, 13'd1, 13'd1, 1'b1};
            r_vld <= 3'd0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[1:0], s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CHANNELS: r_cfg.channel_count <= sat;
                    REG_HEIGHT:   r_cfg.tensor_height <= sat;
                    REG_WIDTH:    r_cfg.tensor_width <= sat;
                    REG_HALF:     r_cfg.half_mode <= i_cfg_data[0];
                    default:      r_cfg <= r_cfg;
                endcase
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            logic [31:0] d1, d2;
            logic [31:0] q;
            assign keep[g] = (ch + 13'(g)) < r_cfg.channel_count;
            nc4p_lane u_lane (
                .i_clk(i_clk), .i_en(en), .i_keep(keep[g]), .i_half(r_cfg.half_mode),
                .i_data(s_axis_tdata[42+32*g +: 32]), .o_data(q)
            );
            always_ff @(posedge i_clk) begin
                if (en) begin
                    d1 <= q;
                    d2 <= d1;
                end
            end
            assign lout[32*g +: 32] = d2;
        end
    endgenerate

    nc4p_index u_index (
        .i_clk(i_clk), .i_en(en), .i_cfg(r_cfg),
        .i_batch(s_axis_tdata[7:0]), .i_block(s_axis_tdata[17:8]),
        .i_row(s_axis_tdata[29:18]), .i_col(s_axis_tdata[41:30]), .o_index(idx)
    );

    assign m_axis_tvalid = r_vld[2];
    assign m_axis_tdata = {4'd0, lout, idx};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("lost word");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("stall without output");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0]) else $error("word dropped");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for nc4_block_pack_fp16_top: directed and random position words,
// with the pack arithmetic predicted in the testbench and compared on every output word.
// Depends on nc4p_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import nc4p_pkg::*;

    typedef struct {
        logic [7:0]  batch;
        logic [9:0]  blk;
        logic [11:0] row;
        logic [11:0] col;
        logic [31:0] lane [4];
    } t_pos;

    typedef struct {
        logic [43:0] dest;
        logic [31:0] lane [4];
    } t_packed;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;

    nc4_block_pack_fp16_top uut (.*);

    always #5 i_clk = ~i_clk;

    logic [12:0] cur_channels = 13'd4;
    logic [12:0] cur_height = 13'd1;
    logic [12:0] cur_width = 13'd1;
    logic        cur_half = 1'b1;

    t_pos    pending_q [$];
    t_packed packed_q [$];
    int      errors = 0;
    int      words_out = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    bit      hold_tx = 1'b0;

    function automatic logic [31:0] fp32_to_half(logic [31:0] x);
        logic [31:0] sgn, e, m, h, rem, s, full, hv;
        sgn = (x >> 16) & 32'h8000;
        e = (x >> 23) & 32'hFF;
        m = x & 32'h7FFFFF;
        if (e == 255) begin
            if (m != 0) return sgn | 32'h7E00 | (m >> 13);
            return sgn | 32'h7BFF;
        end
        if (e >= 143) return sgn | 32'h7BFF;
        if (e >= 113) begin
            h = ((e - 112) << 10) | (m >> 13);
            rem = m & 32'h1FFF;
            if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h = h + 1;
            if (h >= 32'h7C00) h = 32'h7BFF;
            return sgn | h;
        end
        if (e == 0) return sgn;
        s = 126 - e;
        if (s > 24) return sgn;
        full = m | 32'h800000;
        h = full >> s;
        rem = full & ((32'd1 << s) - 1);
        hv = 32'd1 << (s - 1);
        if (rem > hv || (rem == hv && h[0])) h = h + 1;
        return sgn | h;
    endfunction

    function automatic t_packed pack_position(t_pos p);
        t_packed r;
        logic [63:0] blocks, idx, ch;
        logic [31:0] v;
        blocks = (64'(cur_channels) + 3) / 4;
        idx = ((((64'(p.batch) * blocks + 64'(p.blk)) * 64'(cur_height) + 64'(p.row))
              * 64'(cur_width)) + 64'(p.col)) * 4;
        r.dest = idx[43:0];
        for (int l = 0; l < 4; l++) begin
            ch = 64'(p.blk) * 4 + l;
            v = (ch < 64'(cur_channels)) ? p.lane[l] : 32'd0;
            r.lane[l] = cur_half ? fp32_to_half(v) : v;
        end
        return r;
    endfunction

    function automatic logic [175:0] pos_bits(t_pos p);
        return {p.lane[3], p.lane[2], p.lane[1], p.lane[0], p.col, p.row, p.blk, p.batch};
    endfunction

    function automatic logic [31:0] rand_fp32();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'(112 + $urandom_range(0, 32));
            1: v[30:23] = 8'($urandom_range(95, 115));
            2: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            3: v[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
            default: ;
        endcase
        return v;
    endfunction

    // Sender: bursts and gaps; each accepted word is predicted at acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                packed_q.push_back(pack_position(pending_q.pop_front()));
                if (burst_left > 0) burst_left <= burst_left - 1;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (burst_left == 0 && !(s_axis_tvalid && s_axis_tready)) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    if (s_axis_tvalid && s_axis_tready && burst_left == 1) begin
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        if (!hold_tx && pending_q.size() > 0) begin
                            s_axis_tvalid <= 1'b1;
                            s_axis_tdata <= pos_bits(pending_q[0]);
                        end else begin
                            s_axis_tvalid <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Receiver stalls on a repeating mask replaced at random now and then.
    logic [15:0] stall_mask = 16'b0010_0110_0000_1011;
    int          stall_pos = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_packed exp_w;
                logic [31:0] act;
                words_out <= words_out + 1;
                if (packed_q.size() == 0) begin
                    $error("output word with nothing expected");
                    errors = errors + 1;
                end else begin
                    exp_w = packed_q.pop_front();
                    if (m_axis_tdata[43:0] !== exp_w.dest) begin
                        $error("dest_index exp %h act %h", exp_w.dest, m_axis_tdata[43:0]);
                        errors = errors + 1;
                    end
                    for (int l = 0; l < 4; l++) begin
                        act = m_axis_tdata[44 + 32*l +: 32];
                        if (act !== exp_w.lane[l]) begin
                            $error("lane%0d_out exp %h act %h", l, exp_w.lane[l], act);
                            errors = errors + 1;
                        end
                    end
                end
            end
            stall_pos <= (stall_pos + 1) % 16;
            if (stall_pos == 15 && $urandom_range(0, 3) == 0)
                stall_mask <= ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
            m_axis_tready <= !stall_mask[stall_pos];
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (pending_q.size() == 0 && packed_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        logic [12:0] ext;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ext = val[12:0];
        if (ext > 13'(MAX_EXTENT)) ext = 13'(MAX_EXTENT);
        case (idx)
            REG_CHANNELS: cur_channels = ext;
            REG_HEIGHT:   cur_height = ext;
            REG_WIDTH:    cur_width = ext;
            REG_HALF:     cur_half = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || packed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_pos(int b, int k, int r, int c, logic [31:0] a0, logic [31:0] a1,
                           logic [31:0] a2, logic [31:0] a3);
        t_pos p;
        p.batch = 8'(b); p.blk = 10'(k); p.row = 12'(r); p.col = 12'(c);
        p.lane[0] = a0; p.lane[1] = a1; p.lane[2] = a2; p.lane[3] = a3;
        pending_q.push_back(p);
    endtask

    task automatic add_random(int n, int cb_max);
        t_pos p;
        for (int i = 0; i < n; i++) begin
            p.batch = 8'($urandom);
            p.blk = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, cb_max));
            p.row = 12'($urandom);
            p.col = 12'($urandom);
            for (int l = 0; l < 4; l++) p.lane[l] = rand_fp32();
            pending_q.push_back(p);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Reset settings: fp16, four channels, 1x1 plane.
        add_pos(0, 0, 0, 0, 32'h3F800000, 32'hBF800000, 32'h477FE000, 32'h477FF000);
        add_pos(255, 1023, 4095, 4095, 32'h7F800000, 32'hFF800000, 32'h7FC00001, 32'hFFBFFFFF);
        add_pos(1, 0, 2, 3, 32'h33800000, 32'h33000001, 32'h387FC000, 32'h00000001);
        add_pos(0, 0, 0, 0, 32'h80000000, 32'h38800000, 32'h3F801000, 32'h3F803000);
        add_pos(0, 1, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        drain();
        write_reg(REG_CHANNELS, 16'd4097);
        write_reg(REG_HEIGHT, 16'hFFFF);
        write_reg(REG_WIDTH, 16'd8191);
        write_reg(REG_HALF, 16'd0);
        add_pos(255, 1023, 4095, 4095, 32'hFFFFFFFF, 32'h00000000, 32'hAAAAAAAA, 32'h55555555);
        add_pos(0, 1023, 0, 0, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0);
        add_random(300, 1023);
        drain();
        write_reg(REG_CHANNELS, 16'd0);
        write_reg(REG_HEIGHT, 16'd0);
        write_reg(REG_HALF, 16'd1);
        add_pos(3, 0, 1, 1, 32'h3F800000, 32'h3F800000, 32'h3F800000, 32'h3F800000);
        add_random(100, 3);
        drain();
        // A run in fp16 with a small partial tensor, paused mid-run until idle.
        write_reg(REG_CHANNELS, 16'd7);
        write_reg(REG_HEIGHT, 16'd5);
        write_reg(REG_WIDTH, 16'd3);
        add_random(500, 2);
        wait (pending_q.size() <= 250);
        hold_tx = 1'b1;
        wait (packed_q.size() == 0 && !s_axis_tvalid);
        hold_tx = 1'b0;
        drain();
        write_reg(REG_CHANNELS, 16'd1);
        write_reg(REG_HEIGHT, 16'd4096);
        write_reg(REG_WIDTH, 16'd1);
        add_random(400, 1);
        drain();
        write_reg(REG_CHANNELS, 16'd4096);
        write_reg(REG_WIDTH, 16'd4096);
        write_reg(REG_HALF, 16'd0);
        add_random(300, 1023);
        drain();
        write_reg(REG_CHANNELS, 16'($urandom_range(1, 64)));
        write_reg(REG_HEIGHT, 16'($urandom_range(1, 64)));
        write_reg(REG_WIDTH, 16'($urandom_range(1, 64)));
        write_reg(REG_HALF, 16'd1);
        add_random(340, 20);
        drain();
        $display("Covered %0d output words over seven register settings, fp16 and fp32,",
                 words_out);
        $display("with extents clamped, zeroed and at the maximum.");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/nc4p_pkg.sv
hdl/nc4p_lane.sv
hdl/nc4p_index.sv
hdl/nc4_block_pack_fp16_top.sv
verif/tb.sv
